FILE: rtl/arl_pkg.sv
// Shared types and constants of the ACK/retry link controller.
// Depends on nothing; the top level, the line parser and the protocol engine import it.
package arl_pkg;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_TICK  = 2'd1,
		OP_FRAME = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_SEND    = 3'd1,
		ACT_NACK    = 3'd2,
		ACT_TIMEOUT = 3'd3,
		ACT_PAUSED  = 3'd4,
		ACT_RESUMED = 3'd5,
		ACT_ACKED   = 3'd6
	} act_t;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_PREFIX = 3'd1,
		PH_GAP    = 3'd2,
		PH_DIGITS = 3'd3,
		PH_TAIL   = 3'd4,
		PH_REJECT = 3'd5
	} ph_t;

	// What the front end hands to the protocol engine for one item
	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_LINE  = 2'd1,
		EV_TICK  = 2'd2,
		EV_FRAME = 2'd3
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic        is_nack;
		logic [31:0] id;
	} ev_t;

	typedef struct packed {
		act_t        action;
		logic [31:0] frame_number;
		logic        ack_pending;
		logic        link_paused;
		logic [7:0]  retry_count;
	} res_t;

	// Configuration register indexes
	localparam logic CFG_ACK_TIMEOUT = 1'b0;
	localparam logic CFG_MAX_RETRIES = 1'b1;

	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd5000;
	localparam logic [7:0]  MAX_RETRIES_RST = 8'd5;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_N     = 8'h4E;

	localparam logic [31:0] VAL_SAT = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;

endpackage

FILE: rtl/ack_retry_link_controller.sv
// Top level of the ACK/retry link controller: line parser front end,
// event queue, protocol engine and result queue. Uses arl_pkg.
//
//   channel   | handshake          | payload
//   ----------+--------------------+--------------------------------------------
//   input     | push / full        | opcode, rx_byte
//   result    | pop / empty        | action, frame_number, ack_pending,
//             |                    | link_paused, retry_count
//   config    | cfg_we             | cfg_idx, cfg_data
//
// One item accepted per cycle while full is low, one result per item, sustained while pop keeps up.
// A result passes the event queue, which registers the event, the protocol engine,
// which handles one a cycle while the result queue is not full, and the result queue.
// Reset clears all state; the ACK timeout resets to 5000, max_retries to 5.
// Each queue holds two transactions; with pop low the result queue fills, then
// the event queue, and full rises.
module ack_retry_link_controller #(
	parameter int LINE_LIMIT = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  action,
	output logic [31:0] frame_number,
	output logic        ack_pending,
	output logic        link_paused,
	output logic [7:0]  retry_count,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data
);
	import arl_pkg::*;

	localparam int EV_W  = $bits(ev_t);
	localparam int RES_W = $bits(res_t);

	ev_t              parser_ev, engine_ev;
	logic [EV_W-1:0]  ev_rdata;
	logic             take, ev_full, ev_empty, ev_pop;
	res_t             engine_res, head_res;
	logic [RES_W-1:0] res_rdata;
	logic             res_full, res_push;

	assign take = push && !ev_full;
	assign full = ev_full;

	arl_line_parser #(
		.LINE_LIMIT(LINE_LIMIT)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.opcode  (opcode),
		.rx_byte (rx_byte),
		.ev      (parser_ev)
	);

	arl_fifo #(
		.WIDTH(EV_W),
		.DEPTH(2)
	) u_ev_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take),
		.wdata  (parser_ev),
		.full   (ev_full),
		.pop    (ev_pop),
		.rdata  (ev_rdata),
		.empty  (ev_empty)
	);

	assign engine_ev = ev_t'(ev_rdata);

	arl_protocol u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.ev       (engine_ev),
		.ev_valid (!ev_empty),
		.ev_pop   (ev_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (engine_res)
	);

	arl_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (engine_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign head_res     = res_t'(res_rdata);
	assign action       = head_res.action;
	assign frame_number = head_res.frame_number;
	assign ack_pending  = head_res.ack_pending;
	assign link_paused  = head_res.link_paused;
	assign retry_count  = head_res.retry_count;

endmodule

FILE: rtl/arl_fifo.sv
// Small register FIFO used as the event queue and the result queue.
// Generic in width and depth; no package dependency.
module arl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fifo occupancy above depth");

endmodule

FILE: rtl/arl_line_parser.sv
// Front end: assembles received bytes into lines and classifies each item
// into an event for the protocol engine. Uses arl_pkg.
module arl_line_parser #(
	parameter int LINE_LIMIT = 200
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [1:0]     opcode,
	input  logic [7:0]     rx_byte,
	output arl_pkg::ev_t   ev
);
	import arl_pkg::*;

	localparam logic [7:0] LIMIT = 8'(LINE_LIMIT);

	logic [7:0]  line_len_q, line_len_d;
	ph_t         phase_q, phase_d;
	logic [2:0]  pfx_pos_q, pfx_pos_d;
	logic        is_nack_q, is_nack_d;
	logic [31:0] pval_q, pval_d;
	logic        vneg_q, vneg_d;
	logic        content_q, content_d;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// Expected prefix character at position pos of "ACK " or "NACK "
	function automatic logic [7:0] prefix_char(input logic nack, input logic [2:0] pos);
		logic [7:0] ch;
		ch = CH_SPACE;
		case (pos)
			3'd0: ch = nack ? CH_N : CH_A;
			3'd1: ch = nack ? CH_A : CH_C;
			3'd2: ch = nack ? CH_C : CH_K;
			3'd3: ch = nack ? CH_K : CH_SPACE;
			default: ch = CH_SPACE;
		endcase
		return ch;
	endfunction

	// value * 10 + digit, saturated at 2^31
	function automatic logic [31:0] add_digit(input logic [31:0] v, input logic [7:0] c);
		logic [35:0] sum;
		sum = (36'(v) << 3) + (36'(v) << 1) + 36'(c[3:0]);
		if (sum > 36'(VAL_SAT)) begin
			return VAL_SAT;
		end
		return sum[31:0];
	endfunction

	always_comb begin
		logic [2:0] plen;
		line_len_d = line_len_q;
		phase_d    = phase_q;
		pfx_pos_d  = pfx_pos_q;
		is_nack_d  = is_nack_q;
		pval_d     = pval_q;
		vneg_d     = vneg_q;
		content_d  = content_q;
		plen       = is_nack_q ? 3'd5 : 3'd4;

		ev.kind    = EV_NONE;
		ev.is_nack = is_nack_q;
		if (vneg_q) begin
			ev.id = 32'd0 - pval_q;
		end else if (pval_q > VAL_MAX) begin
			ev.id = VAL_MAX;
		end else begin
			ev.id = pval_q;
		end

		case (op_t'(opcode))
			OP_BYTE: begin
				if (rx_byte == CH_LF) begin
					ev.kind    = content_q ? EV_LINE : EV_NONE;
					line_len_d = '0;
					phase_d    = PH_LEAD;
					pfx_pos_d  = '0;
					is_nack_d  = 1'b0;
					pval_d     = '0;
					vneg_d     = 1'b0;
					content_d  = 1'b0;
				end else if (rx_byte != CH_CR && line_len_q < LIMIT) begin
					line_len_d = line_len_q + 8'd1;
					case (phase_q)
						PH_LEAD: begin
							if (!is_blank(rx_byte)) begin
								if (rx_byte == CH_A || rx_byte == CH_N) begin
									is_nack_d = (rx_byte == CH_N);
									pfx_pos_d = 3'd1;
									phase_d   = PH_PREFIX;
								end else begin
									phase_d = PH_REJECT;
								end
							end
						end
						PH_PREFIX: begin
							if (pfx_pos_q >= plen ||
								rx_byte != prefix_char(is_nack_q, pfx_pos_q)) begin
								phase_d = PH_REJECT;
							end else begin
								pfx_pos_d = pfx_pos_q + 3'd1;
								if (pfx_pos_q + 3'd1 == plen) begin
									phase_d = PH_GAP;
								end
							end
						end
						PH_GAP: begin
							if (!is_blank(rx_byte)) begin
								content_d = 1'b1;
								if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
									vneg_d  = (rx_byte == CH_MINUS);
									phase_d = PH_DIGITS;
								end else if (is_digit(rx_byte)) begin
									pval_d  = add_digit(pval_q, rx_byte);
									phase_d = PH_DIGITS;
								end else begin
									phase_d = PH_TAIL;
								end
							end
						end
						PH_DIGITS: begin
							if (is_digit(rx_byte)) begin
								pval_d = add_digit(pval_q, rx_byte);
							end else begin
								phase_d = PH_TAIL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			OP_TICK:  ev.kind = EV_TICK;
			OP_FRAME: ev.kind = EV_FRAME;
			default:  ev.kind = EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			phase_q    <= PH_LEAD;
			pfx_pos_q  <= '0;
			is_nack_q  <= 1'b0;
			pval_q     <= '0;
			vneg_q     <= 1'b0;
			content_q  <= 1'b0;
		end else if (take) begin
			line_len_q <= line_len_d;
			phase_q    <= phase_d;
			pfx_pos_q  <= pfx_pos_d;
			is_nack_q  <= is_nack_d;
			pval_q     <= pval_d;
			vneg_q     <= vneg_d;
			content_q  <= content_d;
		end
	end

	a_prefix_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PREFIX) |-> (pfx_pos_q >= 3'd1 && pfx_pos_q <= 3'd4))
		else $error("prefix position out of range while matching prefix");

	a_value_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pval_q <= VAL_SAT)
		else $error("parsed magnitude above saturation point");

endmodule

FILE: rtl/arl_protocol.sv
// Back end: stop-and-wait state (frame number, wait, pause, retries, timer)
// and the configuration registers. Uses arl_pkg.
module arl_protocol (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic [15:0]   cfg_data,
	input  arl_pkg::ev_t  ev,
	input  logic          ev_valid,
	output logic          ev_pop,
	input  logic          res_full,
	output logic          res_push,
	output arl_pkg::res_t res
);
	import arl_pkg::*;

	logic [15:0] timeout_q;
	logic [7:0]  max_retries_q;
	logic [31:0] fc_q, fc_d;
	logic        waiting_q, waiting_d;
	logic        paused_q, paused_d;
	logic [7:0]  ts_q, ts_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic        go;

	assign go       = ev_valid && !res_full;
	assign ev_pop   = go;
	assign res_push = go;

	always_comb begin
		logic [7:0] ts_inc;
		act_t       act;
		fc_d      = fc_q;
		waiting_d = waiting_q;
		paused_d  = paused_q;
		ts_d      = ts_q;
		elapsed_d = elapsed_q;
		act       = ACT_NONE;
		ts_inc    = (ts_q != 8'hFF) ? ts_q + 8'd1 : ts_q;

		case (ev.kind)
			EV_TICK: begin
				if (elapsed_q != 16'hFFFF) begin
					elapsed_d = elapsed_q + 16'd1;
				end
				if (waiting_q && elapsed_q >= timeout_q) begin
					ts_d = ts_inc;
					if (ts_inc >= max_retries_q) begin
						paused_d  = 1'b1;
						waiting_d = 1'b0;
						act       = ACT_PAUSED;
					end else if (!paused_q) begin
						elapsed_d = '0;
						waiting_d = 1'b1;
						act       = ACT_TIMEOUT;
					end
				end
			end
			EV_FRAME: begin
				if (!waiting_q) begin
					fc_d = fc_q + 32'd1;
					if (!paused_q) begin
						elapsed_d = '0;
						waiting_d = 1'b1;
						act       = ACT_SEND;
					end
				end
			end
			EV_LINE: begin
				if (!ev.is_nack) begin
					if (ev.id == fc_q) begin
						waiting_d = 1'b0;
						ts_d      = '0;
						act       = ACT_ACKED;
					end
					if (paused_q) begin
						paused_d  = 1'b0;
						ts_d      = '0;
						waiting_d = 1'b0;
						act       = ACT_RESUMED;
					end
				end else if (ev.id == fc_q && !paused_q) begin
					elapsed_d = '0;
					waiting_d = 1'b1;
					act       = ACT_NACK;
				end
			end
			default: begin
			end
		endcase

		res.action       = act;
		res.frame_number = fc_d;
		res.ack_pending  = waiting_d;
		res.link_paused  = paused_d;
		res.retry_count  = ts_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= ACK_TIMEOUT_RST;
			max_retries_q <= MAX_RETRIES_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ACK_TIMEOUT: timeout_q     <= cfg_data;
				CFG_MAX_RETRIES: max_retries_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q      <= '0;
			waiting_q <= 1'b0;
			paused_q  <= 1'b0;
			ts_q      <= '0;
			elapsed_q <= '0;
		end else if (go) begin
			fc_q      <= fc_d;
			waiting_q <= waiting_d;
			paused_q  <= paused_d;
			ts_q      <= ts_d;
			elapsed_q <= elapsed_d;
		end
	end

	a_wait_xor_pause: assert property (@(posedge clk) disable iff (!arst_n)
		!(waiting_q && paused_q))
		else $error("link waiting for an ACK while paused");

	a_frame_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fc_q != $past(fc_q)) |-> (fc_q == $past(fc_q) + 32'd1))
		else $error("frame number moved by other than one");

endmodule
